>>> src/eevdf_pkg.sv
// Package for the EEVDF virtual-time accounting block.
// Holds event codes, register indexes, reset values and shared types.
`timescale 1ns / 1ps
package eevdf_pkg;

	typedef enum logic [1:0] {
		EV_ENABLE = 2'd0,
		EV_ENQUEUE = 2'd1,
		EV_QUIESCENT = 2'd2,
		EV_CHWEIGHT = 2'd3
	} ev_t;

	localparam logic [0:0] REG_QUANTUM = 1'b0;
	localparam logic [0:0] REG_CPU = 1'b1;
	localparam int CFG_IDX_W = 1;

	localparam logic [31:0] QUANTUM_RESET = 32'd10000000;
	localparam logic [10:0] CPU_RESET = 11'd22;

	localparam int LAG_W = 32;
	localparam int WGT_W = 14;
	localparam int ENTRY_W = LAG_W + WGT_W;

	// Request to the shared divider and its answer.
	typedef struct packed {
		logic start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [63:0] quot;
	} div_rsp_t;

endpackage

>>> src/eevdf_if.sv
// Valid/ready channel interfaces for the EEVDF block.
// Depends on nothing; one interface for events, one for results, one for config.
`timescale 1ns / 1ps
interface eevdf_in_if;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [5:0] client_id;
	logic [63:0] now_ns;
	logic [13:0] target_weight;
	logic [31:0] remaining_slice;
	logic sleeping;
	modport source (output valid, req_type, client_id, now_ns, target_weight,
		remaining_slice, sleeping, input ready);
	modport sink (input valid, req_type, client_id, now_ns, target_weight,
		remaining_slice, sleeping, output ready);
endinterface

interface eevdf_out_if;
	logic valid;
	logic ready;
	logic request_valid;
	logic [63:0] eligible_time;
	logic [63:0] virtual_deadline;
	logic [63:0] virtual_time_now;
	logic signed [31:0] weight_sum;
	modport source (output valid, request_valid, eligible_time, virtual_deadline,
		virtual_time_now, weight_sum, input ready);
	modport sink (input valid, request_valid, eligible_time, virtual_deadline,
		virtual_time_now, weight_sum, output ready);
endinterface

interface eevdf_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/eevdf_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module eevdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/eevdf_div.sv
// Iterative 64-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on eevdf_pkg. A zero divisor gives a zero quotient.
`timescale 1ns / 1ps
module eevdf_div
	import eevdf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);
	logic [63:0] quot_q;
	logic [63:0] rem_q;
	logic [63:0] den_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic zero_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	assign shifted = {rem_q, quot_q[63]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
			zero_q <= (req.den == 64'd0);
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quot_q <= {quot_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quot_q <= {quot_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = zero_q ? 64'd0 : quot_q;
endmodule

>>> src/eevdf_virtual_time_accounting.sv
// EEVDF virtual-time accounting: sequencer, client table RAM and shared 64-bit divider.
// Ignored or sleeping events and enable use no division, repeat enqueue one, leaving
// quiescent two, first enqueue and change weight three; the divisions run one after another.
// Flow: one event in flight; the next is taken only after its result has been accepted
// on the result channel and the sequencer is back in idle, so up to three divisions apply.
// Reset: arst_n clears clock, total weight, timestamp and joined flags and loads the register reset values.
`timescale 1ns / 1ps
module eevdf_virtual_time_accounting
	import eevdf_pkg::*;
#(
	parameter int MAX_CLIENTS = 64
) (
	input logic clk,
	input logic arst_n,
	eevdf_in_if.sink in_ch,
	eevdf_out_if.source out_ch,
	eevdf_cfg_if.sink cfg
);
	localparam int AW = $clog2(MAX_CLIENTS);

	// One-hot sequencer states. ST_MULT, ST_LAGM, and ST_DECODE or ST_LAG1_W start
	// the divider for the wait states ST_ADV_W, ST_LAG1_W and ST_DL_W respectively.
	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_READ = 11'b00000000010,
		ST_DECODE = 11'b00000000100,
		ST_MULT = 11'b00000001000,
		ST_ADV_W = 11'b00000010000,
		ST_LAG1_W = 11'b00000100000,
		ST_LAG2_W = 11'b00001000000,
		ST_DL_W = 11'b00010000000,
		ST_WRITE = 11'b00100000000,
		ST_OUT = 11'b01000000000,
		ST_LAGM = 11'b10000000000
	} st_t;

	st_t st_q;

	logic [31:0] quantum_q;
	logic [10:0] cpu_q;
	logic [63:0] vclock_q;
	logic [31:0] total_q;
	logic [63:0] last_ts_q;
	logic [MAX_CLIENTS-1:0] joined_q;

	// Latched event.
	logic [1:0] type_q;
	logic [AW-1:0] id_q;
	logic [63:0] now_q;
	logic [13:0] nw_q;
	logic [31:0] slice_q;
	logic sleep_q;
	logic inrange_q;

	logic [31:0] lag_q;
	logic [13:0] wgt_q;
	logic [63:0] prod_q;
	logic [63:0] den_q;
	logic lagneg_q;
	// Which lag step is running: 0 first correction, 1 second correction.
	logic step2_q;
	logic req_q;
	logic [63:0] ve_q;
	logic [63:0] vd_q;
	logic start_q;

	logic ram_we;
	logic [AW-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	div_req_t dreq;
	div_rsp_t drsp;

	logic ev_en, ev_enq, ev_qui, ev_chw;
	logic rep_enq;
	logic [31:0] wgt_ext;
	logic [31:0] nw_ext;
	logic [31:0] adv_total;
	logic [31:0] lag_mag;
	logic [31:0] lag_den;
	logic [63:0] corr;

	// Sign-extended 32-bit value as a 64-bit unsigned divisor.
	function automatic logic [63:0] sx32(input logic [31:0] v);
		sx32 = {{32{v[31]}}, v};
	endfunction

	// The table is read with the address of the incoming transaction while idle,
	// so the entry is ready in ST_READ. All writes of an event land before
	// its result is offered, so a read never overlaps a write to the same entry.
	assign ram_raddr = (st_q == ST_IDLE) ? AW'(in_ch.client_id) : id_q;
	assign ram_wdata = {lag_q, wgt_q};

	eevdf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CLIENTS)) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(id_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign dreq.start = start_q;
	assign dreq.num = prod_q;
	assign dreq.den = den_q;

	eevdf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	assign in_ch.ready = (st_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_ch.valid = (st_q == ST_OUT);
	assign out_ch.request_valid = req_q;
	assign out_ch.eligible_time = ve_q;
	assign out_ch.virtual_deadline = vd_q;
	assign out_ch.virtual_time_now = vclock_q;
	assign out_ch.weight_sum = total_q;

	assign ev_en = (type_q == EV_ENABLE);
	assign ev_enq = (type_q == EV_ENQUEUE);
	assign ev_qui = (type_q == EV_QUIESCENT);
	assign ev_chw = (type_q == EV_CHWEIGHT);
	assign rep_enq = inrange_q && ev_enq && joined_q[id_q];

	assign wgt_ext = {18'd0, wgt_q};
	assign nw_ext = {18'd0, nw_q};

	// A first enqueue adds the weight and a leaving quiescent removes it before
	// the clock advances; change weight advances with the old total.
	assign adv_total = ev_enq ? total_q + wgt_ext :
		ev_qui ? total_q - wgt_ext : total_q;

	assign lag_mag = lag_q[31] ? (32'd0 - lag_q) : lag_q;

	// The divisor of the current lag step.
	assign lag_den = (ev_chw && !step2_q) ? total_q - wgt_ext : total_q;

	assign corr = lagneg_q ? (64'd0 - drsp.quot) : drsp.quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			quantum_q <= QUANTUM_RESET;
			cpu_q <= CPU_RESET;
			vclock_q <= '0;
			total_q <= '0;
			last_ts_q <= '0;
			joined_q <= '0;
			start_q <= 1'b0;
			ram_we <= 1'b0;
		end else begin
			start_q <= 1'b0;
			ram_we <= 1'b0;
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_QUANTUM: quantum_q <= cfg.data;
					REG_CPU: cpu_q <= cfg.data[10:0];
					default: ;
				endcase
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						st_q <= ST_READ;
					end
				end
				ST_READ: st_q <= ST_DECODE;
				ST_DECODE: begin
					if (!inrange_q || (ev_qui && sleep_q)) begin
						st_q <= ST_OUT;
					end else if (ev_en) begin
						joined_q[id_q] <= 1'b0;
						ram_we <= 1'b1;
						st_q <= ST_WRITE;
					end else if (rep_enq) begin
						// The new lag is written while the deadline is divided.
						ram_we <= 1'b1;
						start_q <= 1'b1;
						st_q <= ST_DL_W;
					end else begin
						total_q <= adv_total;
						if (ev_enq) begin
							joined_q[id_q] <= 1'b1;
						end else if (ev_qui) begin
							joined_q[id_q] <= 1'b0;
						end
						last_ts_q <= now_q;
						st_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					start_q <= 1'b1;
					st_q <= ST_ADV_W;
				end
				ST_ADV_W: begin
					if (drsp.done) begin
						vclock_q <= vclock_q + drsp.quot;
						st_q <= ST_LAGM;
					end
				end
				ST_LAGM: begin
					start_q <= 1'b1;
					st_q <= ST_LAG1_W;
				end
				ST_LAG1_W: begin
					if (drsp.done) begin
						if (ev_qui || (ev_chw && !step2_q)) begin
							vclock_q <= vclock_q + corr;
						end else begin
							vclock_q <= vclock_q - corr;
						end
						if (ev_chw && !step2_q) begin
							total_q <= total_q + nw_ext - wgt_ext;
							ram_we <= 1'b1;
							st_q <= ST_LAGM;
						end else if (ev_enq) begin
							start_q <= 1'b1;
							st_q <= ST_DL_W;
						end else begin
							st_q <= ST_WRITE;
						end
					end
				end
				ST_DL_W: begin
					if (drsp.done) begin
						st_q <= ST_OUT;
					end
				end
				ST_WRITE: st_q <= ST_OUT;
				ST_OUT: begin
					if (out_ch.ready) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Event latch, table read and divider operand selection.
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					type_q <= in_ch.req_type;
					id_q <= AW'(in_ch.client_id);
					inrange_q <= ({26'd0, in_ch.client_id} < 32'(MAX_CLIENTS));
					now_q <= in_ch.now_ns;
					nw_q <= in_ch.target_weight;
					slice_q <= in_ch.remaining_slice;
					sleep_q <= in_ch.sleeping;
					req_q <= 1'b0;
					ve_q <= '0;
					vd_q <= '0;
				end
			end
			ST_READ: begin
				lag_q <= ram_rdata[ENTRY_W-1:WGT_W];
				wgt_q <= ram_rdata[WGT_W-1:0];
			end
			ST_DECODE: begin
				if (ev_en) begin
					lag_q <= '0;
					wgt_q <= nw_q;
				end else if (rep_enq) begin
					lag_q <= slice_q;
					ve_q <= vclock_q;
					prod_q <= {32'd0, quantum_q};
					den_q <= {50'd0, wgt_q};
				end else begin
					prod_q <= {53'd0, cpu_q} * (now_q - last_ts_q);
					den_q <= sx32(adv_total);
				end
			end
			ST_ADV_W: begin
				if (drsp.done) begin
					step2_q <= 1'b0;
				end
			end
			ST_LAGM: begin
				prod_q <= {53'd0, cpu_q} * {32'd0, lag_mag};
				den_q <= sx32(lag_den);
				lagneg_q <= lag_q[31];
			end
			ST_LAG1_W: begin
				if (drsp.done) begin
					if (ev_chw && !step2_q) begin
						wgt_q <= nw_q;
						step2_q <= 1'b1;
					end else if (ev_enq) begin
						ve_q <= vclock_q - corr;
						prod_q <= {32'd0, quantum_q};
						den_q <= {50'd0, wgt_q};
					end
				end
			end
			ST_DL_W: begin
				if (drsp.done) begin
					vd_q <= ve_q + drsp.quot;
					req_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule

>>> src/eevdf_chk.sv
// Port-level checker for the EEVDF block, bound to the top level.
// Depends on eevdf_virtual_time_accounting port names.
`timescale 1ns / 1ps
module eevdf_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_req,
	input logic [63:0] out_ve,
	input logic [63:0] out_vd
);
	// No new event while a result is pending.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("event accepted while result pending");

	// A result stays until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");

	// No request means zero times.
	a_noreq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_req |-> out_ve == 64'd0 && out_vd == 64'd0)
		else $error("times without request");

	// The block is busy right after it takes an event.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second event taken at once");
endmodule

bind eevdf_virtual_time_accounting eevdf_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_req(out_ch.request_valid),
	.out_ve(out_ch.eligible_time),
	.out_vd(out_ch.virtual_deadline)
);

>>> verif/eevdf_vta_checker.sv
// Checker for the EEVDF virtual-time accounting block: watches the event,
// result and register channels, predicts each result and compares it.
// Depends on eevdf_pkg and the channel interfaces in src/eevdf_if.sv.
`timescale 1ns / 1ps
module eevdf_vta_checker
	import eevdf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	eevdf_in_if in_ch,
	eevdf_out_if out_ch,
	eevdf_cfg_if cfg,
	output int fail_count,
	output int pending_count
);
	typedef struct packed {
		logic request_valid;
		logic [63:0] eligible_time;
		logic [63:0] virtual_deadline;
		logic [63:0] virtual_time_now;
		logic [31:0] weight_sum;
	} sched_result_t;

	sched_result_t expected_results[$];

	logic [31:0] quantum;
	logic [10:0] cpus;
	logic [63:0] vclock;
	logic [31:0] weight_total;
	logic [63:0] last_ns;
	logic [31:0] lag_tab[64];
	logic [13:0] weight_tab[64];
	logic joined_tab[64];

	function automatic logic [63:0] div0(logic [63:0] n, logic [63:0] d);
		return (d == 0) ? 64'd0 : n / d;
	endfunction

	function automatic logic [63:0] sext32(logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	// Sign-magnitude lag scaling, returned as a two's complement pattern.
	function automatic logic [63:0] lag_scaled(logic [31:0] lag, logic [31:0] wgt);
		logic [63:0] mag;
		logic [63:0] adj;
		mag = lag[31] ? {32'd0, 32'd0 - lag} : {32'd0, lag};
		adj = div0(64'(cpus) * mag, sext32(wgt));
		return lag[31] ? 64'd0 - adj : adj;
	endfunction

	task automatic advance_vclock(logic [63:0] now);
		logic [63:0] delta;
		delta = now - last_ns;
		last_ns = now;
		vclock = vclock + div0(64'(cpus) * delta, sext32(weight_total));
	endtask

	task automatic predict_event(ev_t kind, int c, logic [63:0] now, logic [13:0] nw,
			logic [31:0] slice, logic sleep);
		sched_result_t r;
		r = '0;
		case (kind)
			EV_ENABLE: begin
				lag_tab[c] = '0;
				weight_tab[c] = nw;
				joined_tab[c] = 1'b0;
			end
			EV_ENQUEUE: begin
				if (!joined_tab[c]) begin
					joined_tab[c] = 1'b1;
					weight_total = weight_total + 32'(weight_tab[c]);
					advance_vclock(now);
					vclock = vclock - lag_scaled(lag_tab[c], weight_total);
				end else begin
					lag_tab[c] = slice;
				end
				r.request_valid = 1'b1;
				r.eligible_time = vclock;
				r.virtual_deadline = vclock + div0(64'(quantum), 64'(weight_tab[c]));
			end
			EV_QUIESCENT: begin
				if (!sleep) begin
					weight_total = weight_total - 32'(weight_tab[c]);
					advance_vclock(now);
					vclock = vclock + lag_scaled(lag_tab[c], weight_total);
					joined_tab[c] = 1'b0;
				end
			end
			default: begin
				advance_vclock(now);
				vclock = vclock + lag_scaled(lag_tab[c], weight_total - 32'(weight_tab[c]));
				weight_total = weight_total + 32'(nw) - 32'(weight_tab[c]);
				weight_tab[c] = nw;
				vclock = vclock - lag_scaled(lag_tab[c], weight_total);
			end
		endcase
		r.virtual_time_now = vclock;
		r.weight_sum = weight_total;
		expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum = QUANTUM_RESET;
			cpus = CPU_RESET;
			vclock = '0;
			weight_total = '0;
			last_ns = '0;
			fail_count = 0;
			expected_results.delete();
			pending_count = 0;
			for (int i = 0; i < 64; i++) begin
				joined_tab[i] = 1'b0;
				lag_tab[i] = '0;
				weight_tab[i] = '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_QUANTUM)
					quantum = cfg.data;
				else
					cpus = cfg.data[10:0];
			end
			if (out_ch.valid && out_ch.ready) begin
				sched_result_t got;
				got = {out_ch.request_valid, out_ch.eligible_time, out_ch.virtual_deadline,
					out_ch.virtual_time_now, out_ch.weight_sum};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transaction: %p", got);
				end else begin
					sched_result_t want;
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result mismatch: expected %p, actual %p", want, got);
					end
				end
			end
			// The event is predicted after the result check, since its result
			// can never appear at the same edge it is accepted.
			if (in_ch.valid && in_ch.ready)
				predict_event(ev_t'(in_ch.req_type), int'(in_ch.client_id), in_ch.now_ns,
					in_ch.target_weight, in_ch.remaining_slice, in_ch.sleeping);
			pending_count = expected_results.size();
		end
	end
endmodule

>>> verif/eevdf_virtual_time_accounting_tb.sv
// Top of the EEVDF virtual-time accounting testbench: clock, reset, stimulus
// and verdict. Depends on eevdf_pkg, src/eevdf_if.sv, the block and the checker.
`timescale 1ns / 1ps
module eevdf_virtual_time_accounting_tb
	import eevdf_pkg::*;
;

	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending_count;
	int cycle_count;

	eevdf_in_if in_ch();
	eevdf_out_if out_ch();
	eevdf_cfg_if cfg();

	eevdf_virtual_time_accounting dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	eevdf_vta_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// Clients that have been enabled at least once; only those may be touched
	// by events that read the lag or weight tables.
	bit enabled[64];
	int enabled_count;
	logic [63:0] now_ns;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The result side draws a stall per transaction, which may be zero.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("eevdf_virtual_time_accounting_tb NOT OK");
			$finish;
		end
	end

	// Sends one event transaction and waits for it to be accepted.
	task automatic send_event(ev_t kind, logic [5:0] id, logic [63:0] now,
			logic [13:0] nw, logic [31:0] slice, logic sleep);
		in_ch.valid <= 1'b1;
		in_ch.req_type <= kind;
		in_ch.client_id <= id;
		in_ch.now_ns <= now;
		in_ch.target_weight <= nw;
		in_ch.remaining_slice <= slice;
		in_ch.sleeping <= sleep;
		do @(posedge clk); while (!in_ch.ready);
		in_ch.valid <= 1'b0;
		if (kind == EV_ENABLE && !enabled[id]) begin
			enabled[id] = 1'b1;
			enabled_count++;
		end
		@(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every expected result has come back, then idles before the next step.
	task automatic drain();
		while (pending_count != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [13:0] rand_weight();
		case ($urandom_range(0, 4))
			0: return 14'd1;
			1: return 14'd10000;
			default: return 14'($urandom_range(1, 10000));
		endcase
	endfunction

	// Mostly small forward steps of real time, sometimes huge or backward jumps.
	function automatic logic [63:0] next_time();
		case ($urandom_range(0, 9))
			0: return {$urandom, $urandom};
			1: return now_ns - 64'($urandom_range(0, 1000));
			default: return now_ns + 64'($urandom_range(0, 5000000));
		endcase
	endfunction

	function automatic logic [31:0] rand_slice();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 10000000);
		endcase
	endfunction

	function automatic logic [5:0] pick_enabled();
		logic [5:0] id;
		do id = 6'($urandom_range(0, 63)); while (!enabled[id]);
		return id;
	endfunction

	task automatic random_events(int count);
		ev_t kind;
		logic [5:0] id;
		for (int n = 0; n < count; n++) begin
			repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10)) @(posedge clk);
			now_ns = next_time();
			if (enabled_count == 0 || $urandom_range(0, 7) == 0) begin
				// Enabling any client keeps later reads of its entry legal.
				send_event(EV_ENABLE, 6'($urandom_range(0, 63)), {$urandom, $urandom},
					rand_weight(), $urandom, 1'($urandom));
			end else begin
				id = pick_enabled();
				kind = ev_t'($urandom_range(1, 3));
				send_event(kind, id, now_ns, rand_weight(), rand_slice(),
					1'($urandom_range(0, 2) == 0));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cycle_count = 0;
		now_ns = 0;
		enabled_count = 0;
		in_ch.valid = 1'b0;
		in_ch.req_type = EV_ENABLE;
		in_ch.client_id = '0;
		in_ch.now_ns = '0;
		in_ch.target_weight = 14'd1;
		in_ch.remaining_slice = '0;
		in_ch.sleeping = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_QUANTUM;
		cfg.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset configuration: extremes of weight, every
		// event, first and repeat enqueue, sleeping and leaving quiescent, a
		// leave without a join, the most negative lag, and a zero total.
		send_event(EV_ENABLE, 6'd0, 64'd0, 14'd1, 32'd0, 1'b0);
		send_event(EV_ENABLE, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 14'd10000, 32'hFFFF_FFFF, 1'b1);
		send_event(EV_ENQUEUE, 6'd0, 64'd1000, 14'd1, 32'd0, 1'b0);
		send_event(EV_ENQUEUE, 6'd63, 64'd5000, 14'd1, 32'd0, 1'b0);
		send_event(EV_ENQUEUE, 6'd0, 64'd6000, 14'd1, 32'h8000_0000, 1'b0);
		send_event(EV_ENQUEUE, 6'd63, 64'd7000, 14'd1, 32'h7FFF_FFFF, 1'b0);
		send_event(EV_QUIESCENT, 6'd0, 64'd9000, 14'd1, 32'd0, 1'b1);
		send_event(EV_QUIESCENT, 6'd0, 64'd12000, 14'd1, 32'd0, 1'b0);
		send_event(EV_CHWEIGHT, 6'd63, 64'd20000, 14'd10000, 32'd0, 1'b0);
		send_event(EV_CHWEIGHT, 6'd63, 64'd30000, 14'd1, 32'd0, 1'b0);
		send_event(EV_QUIESCENT, 6'd63, 64'd40000, 14'd1, 32'd0, 1'b0);
		send_event(EV_QUIESCENT, 6'd63, 64'd50000, 14'd1, 32'd0, 1'b0);
		send_event(EV_ENQUEUE, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 14'd1, 32'd0, 1'b0);
		send_event(EV_CHWEIGHT, 6'd0, 64'd10, 14'd5000, 32'hFFFF_FFFF, 1'b1);
		enabled[0] = 1'b1;
		enabled[63] = 1'b1;
		enabled_count = 2;
		drain();

		// Quantum extremes, random and reset settings, each with random traffic after it.
		write_register(REG_QUANTUM, 32'hFFFF_FFFF);
		write_register(REG_CPU, 32'd1024);
		random_events(400);
		drain();
		write_register(REG_QUANTUM, 32'd1);
		write_register(REG_CPU, 32'd1);
		random_events(400);
		drain();
		write_register(REG_QUANTUM, $urandom);
		write_register(REG_CPU, 32'($urandom_range(1, 1024)));
		random_events(550);
		drain();
		write_register(REG_QUANTUM, QUANTUM_RESET);
		write_register(REG_CPU, 32'(CPU_RESET));
		random_events(580);

		while (pending_count != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("eevdf_virtual_time_accounting_tb OK");
		else
			$display("eevdf_virtual_time_accounting_tb NOT OK");
		$finish;
	end
endmodule
